// ===== sv/gnms_pkg.sv =====
`timescale 1ns / 1ps

package gnms_pkg;

  // Fixed field widths of the channels
  localparam int unsigned TAG_W   = 16;
  localparam int unsigned EDGE_W  = 16;
  localparam int unsigned THR_W   = 17;
  localparam int unsigned COUNT_W = 7;

  // Threshold value that stands for an IoU of 1.0
  localparam logic [THR_W-1:0] THR_ONE = 17'h10000;
  localparam logic [THR_W-1:0] THR_RESET = 17'h04000;

  // Sequencer states
  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_AREA   = 5'b00010,
    ST_SCAN   = 5'b00100,
    ST_DRAIN  = 5'b01000,
    ST_DECIDE = 5'b10000
  } state_t;

  // Controls from the sequencer into the overlap pipeline
  typedef struct packed {
    logic clear;      // forget any earlier suppression
    logic load_area;  // push the candidate's own area through the multiplier
    logic cmp_valid;  // a kept box is on the read data this cycle
  } iou_ctl_t;

  // Status back from the overlap pipeline
  typedef struct packed {
    logic busy;       // some stage still holds work
    logic suppress;   // a kept box overlapped too much
  } iou_sts_t;

endpackage

// ===== sv/gnms_iou.sv =====
`timescale 1ns / 1ps

module gnms_iou #(
  parameter int unsigned CW = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  gnms_pkg::iou_ctl_t        ctl,
  input  logic [gnms_pkg::THR_W-1:0] thr,
  input  logic [CW-1:0]             cx0,
  input  logic [CW-1:0]             cy0,
  input  logic [CW-1:0]             cx1,
  input  logic [CW-1:0]             cy1,
  input  logic [CW-1:0]             kx0,
  input  logic [CW-1:0]             ky0,
  input  logic [CW-1:0]             kx1,
  input  logic [CW-1:0]             ky1,
  input  logic [2*CW-1:0]           karea,
  output logic [2*CW-1:0]           cand_area,
  output gnms_pkg::iou_sts_t        sts
);

  localparam int unsigned AW = 2 * CW;
  localparam int unsigned PW = 2 * CW + 18;

  // Stage 1: overlap extent or candidate extent
  logic          v1_r, isa1_r, pos1_r;
  logic [CW-1:0] w1_r, h1_r;
  logic [AW-1:0] areab1_r;
  // Stage 2: product
  logic          v2_r, isa2_r, pos2_r;
  logic [AW-1:0] inter2_r, areab2_r;
  // Stage 3: union
  logic          v3_r, pos3_r;
  logic [AW:0]   uni3_r;
  logic [AW-1:0] inter3_r;
  // Stage 4: threshold times union
  logic          v4_r, pos4_r;
  logic [PW-1:0] prod4_r;
  logic [AW-1:0] inter4_r;

  logic [AW-1:0] area_r;
  logic          sup_r;

  logic [CW-1:0] lft, top, rgt, bot;
  logic          ovl_pos;
  logic [PW-1:0] lhs;

  // Overlap corners
  always_comb begin
    lft = (cx0 > kx0) ? cx0 : kx0;
    top = (cy0 > ky0) ? cy0 : ky0;
    rgt = (cx1 < kx1) ? cx1 : kx1;
    bot = (cy1 < ky1) ? cy1 : ky1;
    ovl_pos = (rgt > lft) && (bot > top);
    lhs = {2'b00, inter4_r, 16'h0000};
  end

  // Valid bits of the stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      isa1_r <= 1'b0;
      v2_r   <= 1'b0;
      isa2_r <= 1'b0;
      v3_r   <= 1'b0;
      v4_r   <= 1'b0;
    end else begin
      v1_r   <= ctl.load_area | ctl.cmp_valid;
      isa1_r <= ctl.load_area;
      v2_r   <= v1_r;
      isa2_r <= isa1_r;
      v3_r   <= v2_r & ~isa2_r;
      v4_r   <= v3_r;
    end
  end

  // Stage 1: extents
  always_ff @(posedge clk) begin
    if (ctl.load_area) begin
      w1_r   <= (cx1 > cx0) ? cx1 - cx0 : '0;
      h1_r   <= (cy1 > cy0) ? cy1 - cy0 : '0;
      pos1_r <= 1'b0;
    end else begin
      w1_r   <= ovl_pos ? rgt - lft : '0;
      h1_r   <= ovl_pos ? bot - top : '0;
      pos1_r <= ovl_pos;
    end
    areab1_r <= karea;
  end

  // Stage 2: the shared multiplier, area or intersection
  always_ff @(posedge clk) begin
    inter2_r <= w1_r * h1_r;
    pos2_r   <= pos1_r;
    areab2_r <= areab1_r;
  end

  // Hold the candidate's area for the whole scan
  always_ff @(posedge clk) begin
    if (v2_r && isa2_r) begin
      area_r <= inter2_r;
    end
  end

  // Stage 3: union, never negative when the overlap is positive
  always_ff @(posedge clk) begin
    uni3_r   <= {1'b0, area_r} + {1'b0, areab2_r} - {1'b0, inter2_r};
    inter3_r <= inter2_r;
    pos3_r   <= pos2_r;
  end

  // Stage 4: scale the union by the threshold
  always_ff @(posedge clk) begin
    prod4_r  <= thr * uni3_r;
    inter4_r <= inter3_r;
    pos4_r   <= pos3_r;
  end

  // Collect suppression over the scan
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sup_r <= 1'b0;
    end else if (ctl.clear) begin
      sup_r <= 1'b0;
    end else if (v4_r && pos4_r && (lhs > prod4_r)) begin
      sup_r <= 1'b1;
    end
  end

  assign cand_area    = area_r;
  assign sts.busy     = v1_r | v2_r | v3_r | v4_r;
  assign sts.suppress = sup_r;

endmodule

// ===== sv/greedy_box_nms.sv =====
`timescale 1ns / 1ps
// Greedy non-maximum suppression over boxes sorted by falling score.
// Input channel (in_*): one box per beat, with its tag and a new_set flag that
// empties the kept list before the box is judged.
// Output channel (out_*): one result beat per box: the tag, kept, list_full
// and the kept count after this box (low 7 bits).
// Config channel (cfg_*): writes the 17-bit IoU threshold (65536 = 1.0); it is
// always ready and should be written only while the block is idle.
// Each box is compared with every kept box through one pipelined overlap unit
// (memory read, extent, multiply, union, threshold multiply, compare) that
// takes one kept box per cycle. The scan reads the kept boxes from memory in
// order, N of them, N being the kept count (up to MAX_KEPT); when the list is
// empty only the candidate's area passes through the unit. The next box is
// accepted only once this box's result is loaded into the output register.
// in_ready is high only between items.
// A finished result sits in the output register until taken; the next box is
// accepted and scanned meanwhile, and it waits at the end of its scan while the
// receiver stalls.
// Reset empties the kept list and sets the threshold to 16384 (0.25). The kept
// memory itself is not cleared; only entries below the count are ever compared.
module greedy_box_nms #(
  parameter int unsigned MAX_KEPT   = 64,
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // config
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [gnms_pkg::THR_W-1:0]       cfg_iou_threshold,
  // input boxes
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_new_set,
  input  logic [gnms_pkg::TAG_W-1:0]       in_box_tag,
  input  logic [gnms_pkg::EDGE_W-1:0]      in_x_min,
  input  logic [gnms_pkg::EDGE_W-1:0]      in_y_min,
  input  logic [gnms_pkg::EDGE_W-1:0]      in_x_max,
  input  logic [gnms_pkg::EDGE_W-1:0]      in_y_max,
  // results
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [gnms_pkg::TAG_W-1:0]       out_tag_out,
  output logic                             out_kept,
  output logic                             out_list_full,
  output logic [gnms_pkg::COUNT_W-1:0]     out_kept_count
);

  localparam int unsigned CW = (COORD_BITS < gnms_pkg::EDGE_W) ? COORD_BITS
                                                               : gnms_pkg::EDGE_W;
  localparam int unsigned KW = $clog2(MAX_KEPT + 1);
  localparam int unsigned IW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
  localparam int unsigned EW = 6 * CW;
  localparam int unsigned OW = gnms_pkg::COUNT_W;

  gnms_pkg::state_t state_r, state_nxt;

  logic [gnms_pkg::THR_W-1:0] thr_r, thr_use;
  logic [gnms_pkg::TAG_W-1:0] tag_r;
  logic [CW-1:0]              cx0_r, cy0_r, cx1_r, cy1_r;
  logic [KW-1:0]              cnt_r, cnt_nxt;
  logic [KW-1:0]              idx_r;
  logic                       rv_r;
  logic [EW-1:0]              mem [MAX_KEPT];
  logic [EW-1:0]              rdata_r;
  logic                       in_fire, out_free, decide_go, store_en, full_now;
  logic [2*CW-1:0]            cand_area;
  logic [KW+OW-1:0]           cnt_ext;

  logic                       out_valid_r, out_kept_r, out_full_r;
  logic [gnms_pkg::TAG_W-1:0] out_tag_r;
  logic [OW-1:0]              out_cnt_r;

  gnms_pkg::iou_ctl_t         ctl;
  gnms_pkg::iou_sts_t         sts;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == gnms_pkg::ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign decide_go = (state_r == gnms_pkg::ST_DECIDE) && out_free;
  assign full_now  = (cnt_r >= KW'(MAX_KEPT));
  assign store_en  = decide_go && !sts.suppress && !full_now;
  assign thr_use   = (thr_r > gnms_pkg::THR_ONE) ? gnms_pkg::THR_ONE : thr_r;

  // Threshold register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= gnms_pkg::THR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      thr_r <= cfg_iou_threshold;
    end
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      gnms_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_nxt = gnms_pkg::ST_AREA;
        end
      end
      gnms_pkg::ST_AREA: begin
        state_nxt = (cnt_r == '0) ? gnms_pkg::ST_DRAIN : gnms_pkg::ST_SCAN;
      end
      gnms_pkg::ST_SCAN: begin
        if (idx_r + KW'(1) == cnt_r) begin
          state_nxt = gnms_pkg::ST_DRAIN;
        end
      end
      gnms_pkg::ST_DRAIN: begin
        if (!rv_r && !sts.busy) begin
          state_nxt = gnms_pkg::ST_DECIDE;
        end
      end
      gnms_pkg::ST_DECIDE: begin
        if (out_free) begin
          state_nxt = gnms_pkg::ST_IDLE;
        end
      end
      default: state_nxt = gnms_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gnms_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Kept count: drop on new_set, advance on store
  always_comb begin
    cnt_nxt = cnt_r;
    if (in_fire && in_new_set) begin
      cnt_nxt = '0;
    end else if (store_en) begin
      cnt_nxt = cnt_r + KW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // Capture the candidate, masked to the coordinate width
  always_ff @(posedge clk) begin
    if (in_fire) begin
      tag_r <= in_box_tag;
      cx0_r <= in_x_min[CW-1:0];
      cy0_r <= in_y_min[CW-1:0];
      cx1_r <= in_x_max[CW-1:0];
      cy1_r <= in_y_max[CW-1:0];
    end
  end

  // Scan index
  always_ff @(posedge clk) begin
    if (state_r == gnms_pkg::ST_AREA) begin
      idx_r <= '0;
    end else if (state_r == gnms_pkg::ST_SCAN) begin
      idx_r <= idx_r + KW'(1);
    end
  end

  // Kept-box memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (store_en) begin
      mem[cnt_r[IW-1:0]] <= {cx0_r, cy0_r, cx1_r, cy1_r, cand_area};
    end
    rdata_r <= mem[idx_r[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rv_r <= 1'b0;
    end else begin
      rv_r <= (state_r == gnms_pkg::ST_SCAN);
    end
  end

  // Overlap pipeline
  assign ctl.clear     = in_fire;
  assign ctl.load_area = (state_r == gnms_pkg::ST_AREA);
  assign ctl.cmp_valid = rv_r;

  gnms_iou #(
    .CW (CW)
  ) u_iou (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .thr       (thr_use),
    .cx0       (cx0_r),
    .cy0       (cy0_r),
    .cx1       (cx1_r),
    .cy1       (cy1_r),
    .kx0       (rdata_r[6*CW-1:5*CW]),
    .ky0       (rdata_r[5*CW-1:4*CW]),
    .kx1       (rdata_r[4*CW-1:3*CW]),
    .ky1       (rdata_r[3*CW-1:2*CW]),
    .karea     (rdata_r[2*CW-1:0]),
    .cand_area (cand_area),
    .sts       (sts)
  );

  // Result register: load on decide, drop when taken
  assign cnt_ext = {{OW{1'b0}}, cnt_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (decide_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (decide_go) begin
      out_tag_r  <= tag_r;
      out_kept_r <= !sts.suppress && !full_now;
      out_full_r <= !sts.suppress && full_now;
      out_cnt_r  <= cnt_ext[OW-1:0];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_tag_out    = out_tag_r;
  assign out_kept       = out_kept_r;
  assign out_list_full  = out_full_r;
  assign out_kept_count = out_cnt_r;

  // Checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= KW'(MAX_KEPT))
    else $error("kept count beyond list depth");

  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_kept_r && out_full_r))
    else $error("kept and list_full both set");

  a_decide_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == gnms_pkg::ST_DECIDE) |-> (!sts.busy && !rv_r))
    else $error("decision taken with overlap pipeline busy");

  a_store_only_decide: assert property (@(posedge clk) disable iff (!rst_n)
    store_en |-> (!rv_r && !sts.busy && !in_fire))
    else $error("kept-box write during scan");

endmodule
